@@ sv/imre_pkg.sv @@
// ----------------------------------------------------------------------------
// imre_pkg
// Shared types and constants of the image rotate and mirror engine.
// ----------------------------------------------------------------------------
package imre_pkg;

	localparam int DIM_W     = 7;
	localparam int MODE_W    = 3;
	localparam int CNT_W     = 2 * DIM_W;
	localparam int PIX_W     = 16;
	localparam int CFG_IDX_W = 2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MODE   = 2'd2;

	localparam logic [DIM_W-1:0]  WIDTH_RST  = 7'd64;
	localparam logic [DIM_W-1:0]  HEIGHT_RST = 7'd64;

	// transform modes
	localparam logic [MODE_W-1:0] MODE_NONE   = 3'd0;
	localparam logic [MODE_W-1:0] MODE_ROT90  = 3'd1;
	localparam logic [MODE_W-1:0] MODE_ROT180 = 3'd2;
	localparam logic [MODE_W-1:0] MODE_ROT270 = 3'd3;
	localparam logic [MODE_W-1:0] MODE_MIR_H  = 3'd4;
	localparam logic [MODE_W-1:0] MODE_MIR_V  = 3'd5;

	// input item operations
	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_FETCH = 1'b1;

	typedef enum logic [1:0] {
		CMD_WRITE,
		CMD_READ,
		CMD_EARLY
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t kind;
		logic      last;
	} cmd_ctrl_t;

endpackage

@@ sv/imre_queue.sv @@
// ----------------------------------------------------------------------------
// imre_queue
// Small command queue between the front and the back of the engine.
// ----------------------------------------------------------------------------
module imre_queue #(
	parameter int W     = 8,
	parameter int DEPTH = 2
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push_valid,
	output logic         push_ready,
	input  logic [W-1:0] push_data,
	output logic         pop_valid,
	input  logic         pop_ready,
	output logic [W-1:0] pop_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_QW = $clog2(DEPTH + 1);

	logic [W-1:0]      slot_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_QW-1:0] count_q;
	logic              push_fire;
	logic              pop_fire;

	assign push_ready = (count_q < CNT_QW'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = slot_q[rd_ptr_q];
	assign push_fire  = push_valid && push_ready;
	assign pop_fire   = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push_fire) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push_fire) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop_fire) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push_fire, pop_fire})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

@@ sv/imre_front.sv @@
// ----------------------------------------------------------------------------
// imre_front
// Takes items and configuration, keeps the load and fetch counters and
// turns items into store writes, store reads or early answers.
// ----------------------------------------------------------------------------
module imre_front import imre_pkg::*; #(
	parameter int MAX_WIDTH  = 64,
	parameter int MAX_HEIGHT = 64,
	parameter int AW         = 12,
	parameter int SW         = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 in_op,
	input  logic [PIX_W-1:0]     in_pixel,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DIM_W-1:0]     cfg_data,
	output logic                 q_push,
	input  logic                 q_ready,
	output cmd_ctrl_t            q_ctrl,
	output logic [AW-1:0]        q_addr,
	output logic [SW-1:0]        q_data
);

	localparam int DIM_MAX = (1 << DIM_W) - 1;
	localparam int EW      = (MAX_WIDTH < DIM_MAX) ? MAX_WIDTH : DIM_MAX;
	localparam int EH      = (MAX_HEIGHT < DIM_MAX) ? MAX_HEIGHT : DIM_MAX;
	localparam int STEP_W  = $clog2(CNT_W + 1);

	typedef enum logic {
		F_RUN,
		F_DIV
	} fstate_t;

	fstate_t           state_q;
	logic [DIM_W-1:0]  width_q;
	logic [DIM_W-1:0]  height_q;
	logic [MODE_W-1:0] mode_q;
	logic [CNT_W-1:0]  load_count_q;
	logic [DIM_W-1:0]  ld_row_q;
	logic [DIM_W-1:0]  ld_col_q;
	logic [DIM_W-1:0]  out_col_q;
	logic [DIM_W-1:0]  out_row_q;
	logic [CNT_W-1:0]  div_q;
	logic [DIM_W-1:0]  rem_q;
	logic [STEP_W-1:0] step_q;

	logic [DIM_W-1:0]  w;
	logic [DIM_W-1:0]  h;
	logic [CNT_W-1:0]  total;
	logic              loaded;
	logic [MODE_W-1:0] mode;
	logic [DIM_W-1:0]  ow;
	logic [DIM_W-1:0]  oh;
	logic [DIM_W-1:0]  ox;
	logic [DIM_W-1:0]  oy;
	logic [DIM_W-1:0]  sr;
	logic [DIM_W-1:0]  sc;
	logic [AW-1:0]     rd_addr;
	logic [AW-1:0]     wr_addr;
	logic              last_fetch;
	logic              accept;
	logic              cfg_wr;
	logic [DIM_W:0]    div_sh;
	logic              div_ge;
	logic [DIM_W-1:0]  div_rem;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid;

	// sizes of zero act as one, oversize acts as the maximum
	always_comb begin
		if (width_q == '0) begin
			w = DIM_W'(1);
		end else if (int'(width_q) > EW) begin
			w = DIM_W'(EW);
		end else begin
			w = width_q;
		end
		if (height_q == '0) begin
			h = DIM_W'(1);
		end else if (int'(height_q) > EH) begin
			h = DIM_W'(EH);
		end else begin
			h = height_q;
		end
	end

	assign total  = CNT_W'(w) * CNT_W'(h);
	assign loaded = (load_count_q >= total);
	assign mode   = (mode_q > MODE_MIR_V) ? MODE_NONE : mode_q;

	always_comb begin
		if (mode == MODE_ROT90 || mode == MODE_ROT270) begin
			ow = h;
			oh = w;
		end else begin
			ow = w;
			oh = h;
		end
	end

	// counters beyond the plane after a resize stick to its last column or row
	assign ox = (out_col_q < ow) ? out_col_q : ow - 1'b1;
	assign oy = (out_row_q < oh) ? out_row_q : oh - 1'b1;

	always_comb begin
		case (mode)
			MODE_ROT90: begin
				sr = ox;
				sc = w - 1'b1 - oy;
			end
			MODE_ROT180: begin
				sr = h - 1'b1 - oy;
				sc = w - 1'b1 - ox;
			end
			MODE_ROT270: begin
				sr = h - 1'b1 - ox;
				sc = oy;
			end
			MODE_MIR_H: begin
				sr = oy;
				sc = w - 1'b1 - ox;
			end
			MODE_MIR_V: begin
				sr = h - 1'b1 - oy;
				sc = ox;
			end
			default: begin
				sr = oy;
				sc = ox;
			end
		endcase
	end

	assign rd_addr    = AW'(sr) * AW'(MAX_WIDTH) + AW'(sc);
	assign wr_addr    = AW'(ld_row_q) * AW'(MAX_WIDTH) + AW'(ld_col_q);
	assign last_fetch = (ox == ow - 1'b1) && (oy == oh - 1'b1);

	assign in_ready = (state_q == F_RUN) && q_ready;
	assign accept   = in_valid && in_ready;

	assign q_push = accept && ((in_op == OP_FETCH) || !loaded);

	always_comb begin
		q_ctrl.kind = (in_op == OP_LOAD) ? CMD_WRITE : (loaded ? CMD_READ : CMD_EARLY);
		q_ctrl.last = (in_op == OP_FETCH) && loaded && last_fetch;
	end

	assign q_addr = (in_op == OP_LOAD) ? wr_addr : rd_addr;
	assign q_data = in_pixel[SW-1:0];

	// one restoring step of load_count / w
	assign div_sh  = {rem_q, div_q[CNT_W-1]};
	assign div_ge  = (div_sh >= {1'b0, w});
	assign div_rem = div_ge ? DIM_W'(div_sh - {1'b0, w}) : div_sh[DIM_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= F_RUN;
			width_q      <= WIDTH_RST;
			height_q     <= HEIGHT_RST;
			mode_q       <= MODE_NONE;
			load_count_q <= '0;
			ld_row_q     <= '0;
			ld_col_q     <= '0;
			out_col_q    <= '0;
			out_row_q    <= '0;
			div_q        <= '0;
			rem_q        <= '0;
			step_q       <= '0;
		end else begin
			if (cfg_wr) begin
				case (cfg_index)
					REG_WIDTH:  width_q  <= cfg_data;
					REG_HEIGHT: height_q <= cfg_data;
					REG_MODE:   mode_q   <= cfg_data[MODE_W-1:0];
					default:    ;
				endcase
			end
			// a new size moves the load position, so work it out again
			if (cfg_wr && (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT)) begin
				state_q <= F_DIV;
				div_q   <= load_count_q;
				rem_q   <= '0;
				step_q  <= STEP_W'(CNT_W);
			end else begin
				case (state_q)
					F_DIV: begin
						if (step_q == '0) begin
							ld_row_q <= div_q[DIM_W-1:0];
							ld_col_q <= rem_q;
							state_q  <= F_RUN;
						end else begin
							div_q  <= {div_q[CNT_W-2:0], div_ge};
							rem_q  <= div_rem;
							step_q <= step_q - 1'b1;
						end
					end
					F_RUN: begin
						if (accept && in_op == OP_LOAD && !loaded) begin
							load_count_q <= load_count_q + 1'b1;
							if (ld_col_q == w - 1'b1) begin
								ld_col_q <= '0;
								ld_row_q <= ld_row_q + 1'b1;
							end else begin
								ld_col_q <= ld_col_q + 1'b1;
							end
						end
						if (accept && in_op == OP_FETCH && loaded) begin
							if (last_fetch) begin
								out_col_q    <= '0;
								out_row_q    <= '0;
								load_count_q <= '0;
								ld_row_q     <= '0;
								ld_col_q     <= '0;
							end else if (ox == ow - 1'b1) begin
								out_col_q <= '0;
								out_row_q <= oy + 1'b1;
							end else begin
								out_col_q <= ox + 1'b1;
								out_row_q <= oy;
							end
						end
					end
					default: state_q <= F_RUN;
				endcase
			end
		end
	end

`ifndef SYNTHESIS
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> q_ready)
		else $error("command pushed into a full queue");

	a_last_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(q_push && q_ctrl.kind == CMD_READ && q_ctrl.last)
		|=> (load_count_q == '0 && out_col_q == '0 && out_row_q == '0))
		else $error("counters did not restart after the last pixel");

	a_write_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(q_push && q_ctrl.kind == CMD_WRITE && !cfg_wr)
		|=> (load_count_q == $past(load_count_q) + 1'b1))
		else $error("store write without a load count step");
`endif

endmodule

@@ sv/imre_back.sv @@
// ----------------------------------------------------------------------------
// imre_back
// Frame store and result path: runs queued writes and reads and holds the
// result item in an output register.
// ----------------------------------------------------------------------------
module imre_back import imre_pkg::*; #(
	parameter int AW    = 12,
	parameter int SW    = 16,
	parameter int WORDS = 4096
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             pop_valid,
	output logic             pop_ready,
	input  cmd_ctrl_t        pop_ctrl,
	input  logic [AW-1:0]    pop_addr,
	input  logic [SW-1:0]    pop_data,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [PIX_W-1:0] out_pixel,
	output logic             out_last,
	output logic             out_not_loaded
);

	logic [SW-1:0]    mem [WORDS];
	logic [SW-1:0]    rd_s1;
	logic             valid_s1;
	logic             last_s1;
	logic             early_s1;
	logic             out_valid_q;
	logic [PIX_W-1:0] out_pixel_q;
	logic             out_last_q;
	logic             out_nl_q;
	logic             pop_is_wr;
	logic             pop_fire;
	logic             s1_adv;

	assign s1_adv    = valid_s1 && (!out_valid_q || out_ready);
	assign pop_is_wr = (pop_ctrl.kind == CMD_WRITE);
	// writes never wait, reads wait for room in the read stage
	assign pop_ready = pop_is_wr || !valid_s1 || s1_adv;
	assign pop_fire  = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (pop_fire && pop_is_wr) begin
			mem[pop_addr] <= pop_data;
		end
		if (pop_fire && pop_ctrl.kind == CMD_READ) begin
			rd_s1 <= mem[pop_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			last_s1     <= 1'b0;
			early_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			out_pixel_q <= '0;
			out_last_q  <= 1'b0;
			out_nl_q    <= 1'b0;
		end else begin
			if (pop_fire && !pop_is_wr) begin
				valid_s1 <= 1'b1;
				last_s1  <= pop_ctrl.last;
				early_s1 <= (pop_ctrl.kind == CMD_EARLY);
			end else if (s1_adv) begin
				valid_s1 <= 1'b0;
			end
			if (s1_adv) begin
				out_valid_q <= 1'b1;
				out_last_q  <= last_s1;
				out_nl_q    <= early_s1;
				out_pixel_q <= early_s1 ? '0 : PIX_W'(rd_s1);
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign out_pixel      = out_pixel_q;
	assign out_last       = out_last_q;
	assign out_not_loaded = out_nl_q;

`ifndef SYNTHESIS
	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && out_valid_q && !out_ready)
		|=> (valid_s1 && $stable(last_s1) && $stable(early_s1)))
		else $error("read stage lost its item under a stall");

	a_early_form: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_nl_q) |-> (!out_last_q && out_pixel_q == '0))
		else $error("early fetch answer carries a pixel or last flag");

	a_early_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(pop_fire && pop_ctrl.kind == CMD_EARLY) |=> (valid_s1 && early_s1))
		else $error("early fetch did not reach the read stage");
`endif

endmodule

@@ sv/image_rotate_mirror_engine_unit.sv @@
// ----------------------------------------------------------------------------
// image_rotate_mirror_engine_unit
// Loads an image plane in raster order and fetches it rotated or mirrored.
//
// Items with tuser low load the next pixel of the plane into the frame store;
// items with tuser high fetch the next pixel of the transformed plane, with
// tlast on its final pixel; a fetch before the plane is complete answers zero
// with tuser set. The block takes one item per cycle while the queue has room
// and no recount runs; loads into an incomplete plane and fetches each take a
// queue slot; store accesses use the single write and read port. A fetch then
// passes the read stage and the output register. A write of frame_width or
// frame_height starts a recount of the load position (one quotient bit per
// cycle), taking no items. The whole plane is reloaded after its last fetch.
// ----------------------------------------------------------------------------
module image_rotate_mirror_engine_unit import imre_pkg::*; #(
	parameter int MAX_WIDTH  = 64,
	parameter int MAX_HEIGHT = 64,
	parameter int PIXEL_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [PIX_W-1:0]     s_axis_tdata,  // pixel_in
	input  logic                 s_axis_tuser,  // op
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [PIX_W-1:0]     m_axis_tdata,  // pixel_out
	output logic                 m_axis_tlast,
	output logic                 m_axis_tuser,  // not_loaded
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DIM_W-1:0]     cfg_data
);

	localparam int WORDS   = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW      = $clog2(WORDS);
	localparam int SW      = (PIXEL_BITS < PIX_W) ? PIXEL_BITS : PIX_W;
	localparam int QW      = $bits(cmd_ctrl_t) + AW + SW;
	localparam int Q_DEPTH = 2;

	logic            q_push;
	logic            q_ready;
	cmd_ctrl_t       q_ctrl;
	logic [AW-1:0]   q_addr;
	logic [SW-1:0]   q_data;
	logic [QW-1:0]   push_vec;
	logic [QW-1:0]   pop_vec;
	logic            pop_valid;
	logic            pop_ready;
	cmd_ctrl_t       pop_ctrl;
	logic [AW-1:0]   pop_addr;
	logic [SW-1:0]   pop_data;

	imre_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.AW         (AW),
		.SW         (SW)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_op     (s_axis_tuser),
		.in_pixel  (s_axis_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.q_push    (q_push),
		.q_ready   (q_ready),
		.q_ctrl    (q_ctrl),
		.q_addr    (q_addr),
		.q_data    (q_data)
	);

	assign push_vec = {q_ctrl, q_addr, q_data};

	imre_queue #(
		.W     (QW),
		.DEPTH (Q_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (q_push),
		.push_ready (q_ready),
		.push_data  (push_vec),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_vec)
	);

	assign {pop_ctrl, pop_addr, pop_data} = pop_vec;

	imre_back #(
		.AW    (AW),
		.SW    (SW),
		.WORDS (WORDS)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.pop_valid      (pop_valid),
		.pop_ready      (pop_ready),
		.pop_ctrl       (pop_ctrl),
		.pop_addr       (pop_addr),
		.pop_data       (pop_data),
		.out_valid      (m_axis_tvalid),
		.out_ready      (m_axis_tready),
		.out_pixel      (m_axis_tdata),
		.out_last       (m_axis_tlast),
		.out_not_loaded (m_axis_tuser)
	);

endmodule
